// File: design/axis_running_variance_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AXIS_RUNNING_VARIANCE_ASSERT_SVH
`define AXIS_RUNNING_VARIANCE_ASSERT_SVH

// holds on every edge
`define RV_ASSERT_ALW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// next-cycle implication
`define RV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/rv_pkg.sv
// ----------------------------------------------------------------------------
// rv_pkg
// Types and constants shared by the running variance block.
// ----------------------------------------------------------------------------
package rv_pkg;

  localparam int MAX_GROUPS_DEF = 64;
  localparam int SLOT_MAX_W     = 10;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] REG_AXIS     = 2'd0;
  localparam logic [1:0] REG_NUM_ROWS = 2'd1;
  localparam logic [1:0] REG_NUM_COLS = 2'd2;

  localparam logic [47:0] VAR_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0]      sample;
    logic [SLOT_MAX_W-1:0]   slot;
    logic                    first;
    logic [15:0]             pos;
    logic [15:0]             size;
    logic [15:0]             gidx;
    logic                    group_end;
    logic                    matrix_end;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_DIV,
    B_MUL,
    B_VDIV,
    B_OUT
  } back_state_t;

endpackage

// File: design/rv_div.sv
// ----------------------------------------------------------------------------
// rv_div
// Restoring serial divider, one quotient bit per cycle, step count per request.
// ----------------------------------------------------------------------------
module rv_div
  import rv_pkg::*;
#(
  parameter int N = 64,
  parameter int D = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  input  logic [6:0]   steps,
  output logic         busy,
  output logic [N-1:0] quotient
);

  logic [D:0]   rem;
  logic [N-1:0] quo;
  logic [D-1:0] dvs;
  logic [6:0]   cnt;
  logic [D:0]   trial;
  logic         take;

  assign trial    = {rem[D-1:0], quo[N-1]};
  assign take     = trial >= {1'b0, dvs};
  assign busy     = cnt != 7'd0;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 7'd0;
    end else if (start) begin
      cnt <= steps;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? trial - {1'b0, dvs} : trial;
      quo <= {quo[N-2:0], take};
    end
  end

endmodule

// File: design/rv_queue.sv
// ----------------------------------------------------------------------------
// rv_queue
// Short request queue between the front and back sections.
// ----------------------------------------------------------------------------
module rv_queue
  import rv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output entry_t rd_entry,
  output logic   empty,
  output logic   full
);

`include "axis_running_variance_assert.svh"

  entry_t     slots [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty    = count == 2'd0;
  assign full     = count == 2'(QUEUE_DEPTH);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  `RV_ASSERT_ALW(a_count_bound, count <= 2'(QUEUE_DEPTH), "queue count over depth")
  `RV_ASSERT_ALW(a_no_overflow, !(push && full && !pop), "push into full queue")
  `RV_ASSERT_NXT(a_grow, push && !pop, count == $past(count) + 2'd1, "count did not grow")
  `RV_ASSERT_NXT(a_shrink, pop && !push, count == $past(count) - 2'd1, "count did not shrink")

endmodule

// File: design/rv_front.sv
// ----------------------------------------------------------------------------
// rv_front
// Accept samples, track row and column, classify each request for the back.
// ----------------------------------------------------------------------------
module rv_front
  import rv_pkg::*;
#(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        restart,
  input  logic        axis,
  input  logic [15:0] num_rows,
  input  logic [6:0]  num_cols,
  input  logic        accept,
  input  logic [31:0] sample,
  output entry_t      entry
);

  localparam int COL_W  = $clog2(MAX_GROUPS + 1);
  localparam int SLOT_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  logic [15:0]    row;
  logic [COL_W-1:0] col;
  logic [15:0]    rows;
  logic [10:0]    cols_raw;
  logic [COL_W-1:0] cols;
  logic [15:0]    r;
  logic [COL_W-1:0] c;
  logic           last_col;
  logic           last_row;

  always_comb begin
    rows     = (num_rows == 16'd0) ? 16'd1 : num_rows;
    cols_raw = (num_cols == 7'd0) ? 11'd1 : {4'd0, num_cols};
    if (cols_raw > 11'(MAX_GROUPS)) cols_raw = 11'(MAX_GROUPS);
    cols     = cols_raw[COL_W-1:0];
    r        = (row >= rows) ? 16'd0 : row;
    c        = (col >= cols) ? '0 : col;
    last_col = c == cols - COL_W'(1);
    last_row = r == rows - 16'd1;
  end

  always_comb begin
    entry            = '0;
    entry.sample     = sample;
    entry.matrix_end = last_row && last_col;
    if (axis) begin
      entry.first     = c == '0;
      entry.pos       = 16'(c) + 16'd1;
      entry.size      = 16'(cols);
      entry.gidx      = r;
      entry.group_end = last_col;
    end else begin
      entry.slot      = SLOT_MAX_W'(c[SLOT_W-1:0]);
      entry.first     = r == 16'd0;
      entry.pos       = r + 16'd1;
      entry.size      = rows;
      entry.gidx      = 16'(c);
      entry.group_end = last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row <= 16'd0;
      col <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? 16'd0 : r + 16'd1;
      end else begin
        col <= c + COL_W'(1);
        row <= r;
      end
    end
  end

endmodule

// File: design/rv_back.sv
// ----------------------------------------------------------------------------
// rv_back
// Welford update per request: memory read, serial divide and multiply for
// later samples, write back, at group end variance divide, result register.
// ----------------------------------------------------------------------------
module rv_back
  import rv_pkg::*;
#(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  entry_t       q_entry,
  output logic         q_pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,
  output logic         m_tlast
);

  localparam int SLOT_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  back_state_t state;
  back_state_t state_next;

  logic [31:0] mem_mean [MAX_GROUPS];
  logic [63:0] mem_m2   [MAX_GROUPS];
  logic [31:0] rd_mean;
  logic [63:0] rd_m2;

  entry_t             item;
  logic [SLOT_W-1:0]  slot;
  logic signed [33:0] delta;
  logic [32:0]        dmag;
  logic               dneg;
  logic signed [33:0] mean;
  logic signed [33:0] mean_calc;
  logic signed [33:0] diff;
  logic [33:0]        mul_a;
  logic [63:0]        mul_b;
  logic [63:0]        acc;
  logic [5:0]         mcnt;
  logic [63:0]        m2_sum;
  logic [63:0]        m2_calc;
  logic [47:0]        var_q;

  logic        div_start;
  logic [63:0] div_dividend;
  logic [15:0] div_divisor;
  logic [6:0]  div_steps;
  logic        div_busy;
  logic [63:0] div_quo;
  logic        mem_we;
  logic        out_free;

  assign slot     = item.slot[SLOT_W-1:0];
  assign out_free = !m_tvalid || m_tready;

  rv_div #(.N(64), .D(16)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_comb begin
    delta     = 34'(item.sample) - 34'($signed(rd_mean));
    mean_calc = dneg ? mean - $signed({1'b0, div_quo[32:0]})
                     : mean + $signed({1'b0, div_quo[32:0]});
    diff      = 34'(item.sample) - mean_calc;
    m2_sum    = rd_m2 + {16'd0, acc[63:16]};
    m2_calc   = (state == B_READ) ? 64'd0 : ((m2_sum < rd_m2) ? '1 : m2_sum);
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!q_empty) state_next = B_READ;
      B_READ: begin
        if (!item.first)         state_next = B_DIV;
        else if (item.group_end) state_next = B_VDIV;
        else                     state_next = B_IDLE;
      end
      B_DIV:  if (!div_busy) state_next = B_MUL;
      B_MUL:  if (mcnt == 6'd0) state_next = item.group_end ? B_VDIV : B_IDLE;
      B_VDIV: if (!div_busy) state_next = B_OUT;
      B_OUT:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = {m2_calc};
    div_divisor  = item.size;
    div_steps    = 7'd64;
    mem_we       = 1'b0;
    case (state)
      B_IDLE: q_pop = !q_empty;
      B_READ: begin
        if (!item.first) begin
          div_start    = 1'b1;
          div_dividend = {(delta[33] ? 33'(-delta) : delta[32:0]), 31'd0};
          div_divisor  = item.pos;
          div_steps    = 7'd33;
        end else begin
          mem_we    = 1'b1;
          div_start = item.group_end;
        end
      end
      B_MUL: begin
        if (mcnt == 6'd0) begin
          mem_we    = 1'b1;
          div_start = item.group_end;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item    <= q_entry;
      rd_mean <= mem_mean[q_entry.slot[SLOT_W-1:0]];
      rd_m2   <= mem_m2[q_entry.slot[SLOT_W-1:0]];
    end
    if (mem_we) begin
      mem_mean[slot] <= (state == B_READ) ? item.sample : mean[31:0];
      mem_m2[slot]   <= m2_calc;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_READ: begin
        if (item.first) mean <= 34'(item.sample);
        else            mean <= 34'($signed(rd_mean));
        dneg <= delta[33];
        dmag <= delta[33] ? 33'(-delta) : delta[32:0];
      end
      B_DIV: begin
        if (!div_busy) begin
          mean  <= mean_calc;
          mul_a <= diff[33] ? 34'(-diff) : diff;
          mul_b <= {31'd0, dmag};
          acc   <= 64'd0;
          mcnt  <= 6'd34;
        end
      end
      B_MUL: begin
        if (mcnt != 6'd0) begin
          if (mul_a[0]) acc <= acc + mul_b;
          mul_a <= mul_a >> 1;
          mul_b <= mul_b << 1;
          mcnt  <= mcnt - 6'd1;
        end
      end
      B_VDIV: begin
        if (!div_busy) var_q <= (div_quo > {16'd0, VAR_MAX}) ? VAR_MAX : div_quo[47:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == B_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && out_free) begin
      m_tdata <= {var_q, mean[31:0], item.gidx};
      m_tlast <= item.matrix_end;
    end
  end

endmodule

// File: design/axis_running_variance.sv
// Processing: a group's first sample is read and written back; later samples add a
// serial divide by the sample count and a serial multiply; a sample that ends a
// group adds the variance divide and the result register.
// The back end works on one sample at a time; s_tready drops while the queue is full.
// Reset: synchronous; clears counters, queue and control, registers to reset values.
// ----------------------------------------------------------------------------
// axis_running_variance
// Streaming per-group mean and population variance with Welford's update.
// ----------------------------------------------------------------------------
module axis_running_variance
  import rv_pkg::*;
#(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // variance [95:48], mean [47:16], group index [15:0]
  output logic        m_tlast
);

  logic        axis;
  logic [15:0] num_rows;
  logic [6:0]  num_cols;
  logic        wr;
  logic        restart;
  logic [1:0]  reg_idx;
  logic        accept;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  entry_t      wr_entry;
  entry_t      rd_entry;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[3:2];
  assign wr       = psel && penable && pwrite;
  assign restart  = wr && (reg_idx == REG_AXIS || reg_idx == REG_NUM_ROWS ||
                           reg_idx == REG_NUM_COLS);
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis     <= 1'b0;
      num_rows <= 16'd1;
      num_cols <= 7'd1;
    end else if (wr) begin
      case (reg_idx)
        REG_AXIS:     axis     <= pwdata[0];
        REG_NUM_ROWS: num_rows <= pwdata[15:0];
        REG_NUM_COLS: num_cols <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_AXIS:     prdata = {31'd0, axis};
      REG_NUM_ROWS: prdata = {16'd0, num_rows};
      REG_NUM_COLS: prdata = {25'd0, num_cols};
      default:      prdata = 32'd0;
    endcase
  end

  rv_front #(.MAX_GROUPS(MAX_GROUPS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .axis     (axis),
    .num_rows (num_rows),
    .num_cols (num_cols),
    .accept   (accept),
    .sample   (s_tdata),
    .entry    (wr_entry)
  );

  rv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .empty    (q_empty),
    .full     (q_full)
  );

  rv_back #(.MAX_GROUPS(MAX_GROUPS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_entry  (rd_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
